### sv/rarm_pkg.sv
// rarm_pkg: types, constants and codes shared by the range add / range max unit
// used by rarm_front, rarm_queue, rarm_back and the top level
package rarm_pkg;

  localparam int unsigned DEPTH       = 1024;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned ADDR_W      = $clog2(DEPTH);

  // fixed widths of the port fields
  localparam int unsigned POS_W = 11;
  localparam int unsigned AMT_W = 32;
  localparam int unsigned RES_W = 32;
  localparam int unsigned CFG_W = 11;

  localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(1024);
  // largest usable length that still fits the position fields
  localparam logic [POS_W-1:0] LEN_CAP =
    POS_W'((DEPTH < (2 ** POS_W) - 1) ? DEPTH : (2 ** POS_W) - 1);

  // most negative stored value
  localparam logic [VALUE_WIDTH-1:0] SIGN_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  // command queue, depth must be a power of two
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_FIN = 2'd1,
    OP_MAX = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CK_ADD,
    CK_FIN,
    CK_MAX,
    CK_REPORT
  } cmd_kind_e;

  typedef enum logic [2:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_ADD_LO,
    BS_ADD_HI,
    BS_FIN_RUN,
    BS_MAX_RUN,
    BS_DONE
  } back_state_e;

  // classified item as handed from front to back
  typedef struct packed {
    cmd_kind_e               kind;
    status_e                 status;
    logic                    neg_min;   // report carries the most negative value
    logic                    sub_hi;    // add also subtracts past the high end
    logic [ADDR_W-1:0]       lo_addr;
    logic [ADDR_W-1:0]       last_addr; // add: entry past the range, walks: last entry
    logic [VALUE_WIDTH-1:0]  amount;
  } cmd_t;

endpackage

### sv/range_add_then_range_max_unit.sv
// range_add_then_range_max_unit: range add, prefix finalize and range max over 1024 entries
// an accepted add reads and writes its low entry, then, when it also takes off past the high
// end, the entry past the range; finalize and query walk their entries, one per cycle through
// the single read port; rejected or empty items go straight to the result register
// throughput: one item at a time in the store sequencer; a 2-entry queue takes items ahead
// reset: a clearing pass writes zero to all 1024 entries, in_ready_o low meanwhile
module range_add_then_range_max_unit
  import rarm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              op_i,
  input  logic [POS_W-1:0]        low_position_i,
  input  logic [POS_W-1:0]        high_position_i,
  input  logic signed [AMT_W-1:0] amount_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [RES_W-1:0] max_value_o,
  output logic [1:0]              status_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_W-1:0]        length_in_use_i
);

  logic             init_done;
  logic             q_full;
  logic             q_empty;
  logic             push;
  logic             pop;
  cmd_t             push_cmd;
  cmd_t             head_cmd;
  logic [RES_W-1:0] max_value;

  rarm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .low_position_i  (low_position_i),
    .high_position_i (high_position_i),
    .amount_i        (amount_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .length_in_use_i (length_in_use_i),
    .init_done_i     (init_done),
    .q_full_i        (q_full),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  rarm_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  rarm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_head_i    (head_cmd),
    .q_empty_i   (q_empty),
    .q_pop_o     (pop),
    .init_done_o (init_done),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .max_value_o (max_value),
    .status_o    (status_o)
  );

  assign max_value_o = $signed(max_value);

endmodule

### sv/rarm_front.sv
// rarm_front: length register, input handshake and item classification
// depends on rarm_pkg; feeds rarm_queue
module rarm_front
  import rarm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              op_i,
  input  logic [POS_W-1:0]        low_position_i,
  input  logic [POS_W-1:0]        high_position_i,
  input  logic signed [AMT_W-1:0] amount_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_W-1:0]        length_in_use_i,
  input  logic                    init_done_i,
  input  logic                    q_full_i,
  output logic                    push_o,
  output cmd_t                    cmd_o
);

  logic [CFG_W-1:0] len_q;
  logic [POS_W-1:0] len_cfg;
  logic [POS_W-1:0] eff_len;
  logic             pos_bad;
  logic             range_empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_RESET;
    end else if (cfg_valid_i) begin
      len_q <= length_in_use_i;
    end
  end

  assign in_ready_o = init_done_i && !q_full_i;
  assign push_o     = in_valid_i && in_ready_o;

  assign len_cfg     = POS_W'(len_q);
  assign eff_len     = (len_cfg > LEN_CAP) ? LEN_CAP : len_cfg;
  assign pos_bad     = (low_position_i == '0) || (low_position_i > eff_len) ||
                       (high_position_i > eff_len);
  assign range_empty = high_position_i < low_position_i;

  always_comb begin
    cmd_o           = '0;
    cmd_o.kind      = CK_REPORT;
    cmd_o.status    = ST_OK;
    cmd_o.amount    = VALUE_WIDTH'(amount_i);
    cmd_o.lo_addr   = ADDR_W'(low_position_i - POS_W'(1));
    unique case (op_i)
      OP_ADD: begin
        if (pos_bad) begin
          cmd_o.status = ST_RANGE;
        end else if (range_empty) begin
          cmd_o.status = ST_EMPTY;
        end else begin
          cmd_o.kind      = CK_ADD;
          cmd_o.sub_hi    = high_position_i < eff_len;
          cmd_o.last_addr = ADDR_W'(high_position_i);
        end
      end
      OP_FIN: begin
        // a store of zero or one entries is already its own prefix sum
        cmd_o.lo_addr = '0;
        if (eff_len > POS_W'(1)) begin
          cmd_o.kind      = CK_FIN;
          cmd_o.last_addr = ADDR_W'(eff_len - POS_W'(1));
        end
      end
      OP_MAX: begin
        if (pos_bad) begin
          cmd_o.status = ST_RANGE;
        end else if (range_empty) begin
          cmd_o.status  = ST_EMPTY;
          cmd_o.neg_min = 1'b1;
        end else begin
          cmd_o.kind      = CK_MAX;
          cmd_o.last_addr = ADDR_W'(high_position_i - POS_W'(1));
        end
      end
      default: begin
        cmd_o.status = ST_RANGE;
      end
    endcase
  end

endmodule

### sv/rarm_queue.sv
// rarm_queue: short command queue between front and back
// depends on rarm_pkg (cmd_t, QDEPTH)
module rarm_queue
  import rarm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t              entries_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o  = count_q == QCNT_W'(QDEPTH);
  assign empty_o = count_q == '0;
  assign head_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

endmodule

### sv/rarm_back.sv
// rarm_back: value store, clearing pass, add / prefix / max sequencer, result register
// depends on rarm_pkg; takes commands from rarm_queue
module rarm_back
  import rarm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             q_head_i,
  input  logic             q_empty_i,
  output logic             q_pop_o,
  output logic             init_done_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [RES_W-1:0] max_value_o,
  output logic [1:0]       status_o
);

  back_state_e state_q, state_d;

  logic [VALUE_WIDTH-1:0] mem_q [DEPTH];
  logic [VALUE_WIDTH-1:0] rdata_q;
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic [ADDR_W-1:0]      mem_raddr;

  logic [ADDR_W-1:0]      idx_q, idx_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  cmd_t                   cmd_q, cmd_d;
  logic [VALUE_WIDTH-1:0] fin_sum;
  logic                   at_last;

  logic                   out_load;
  logic                   out_valid_q;
  logic [RES_W-1:0]       out_max_q, out_max_d;
  status_e                out_status_q;

  // store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  assign fin_sum = (idx_q == '0) ? rdata_q : rdata_q + acc_q;
  assign at_last = idx_q == cmd_q.last_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    acc_d     = acc_q;
    cmd_d     = cmd_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = '0;
    mem_raddr = idx_q + ADDR_W'(1);
    q_pop_o   = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      BS_CLEAR: begin
        mem_we = 1'b1;
        idx_d  = idx_q + ADDR_W'(1);
        if (idx_q == ADDR_W'(DEPTH - 1)) begin
          state_d = BS_IDLE;
        end
      end
      BS_IDLE: begin
        // first read goes out while the command is taken
        mem_raddr = q_head_i.lo_addr;
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_head_i;
          idx_d   = q_head_i.lo_addr;
          acc_d   = SIGN_MIN;
          unique case (q_head_i.kind)
            CK_ADD:    state_d = BS_ADD_LO;
            CK_FIN:    state_d = BS_FIN_RUN;
            CK_MAX:    state_d = BS_MAX_RUN;
            CK_REPORT: state_d = BS_DONE;
            default:   state_d = BS_DONE;
          endcase
        end
      end
      BS_ADD_LO: begin
        mem_we    = 1'b1;
        mem_waddr = cmd_q.lo_addr;
        mem_wdata = rdata_q + cmd_q.amount;
        mem_raddr = cmd_q.last_addr;
        state_d   = cmd_q.sub_hi ? BS_ADD_HI : BS_DONE;
      end
      BS_ADD_HI: begin
        mem_we    = 1'b1;
        mem_waddr = cmd_q.last_addr;
        mem_wdata = rdata_q - cmd_q.amount;
        state_d   = BS_DONE;
      end
      BS_FIN_RUN: begin
        // entry zero keeps its value and only seeds the running sum
        mem_we    = idx_q != '0;
        mem_wdata = fin_sum;
        acc_d     = fin_sum;
        if (at_last) begin
          state_d = BS_DONE;
        end else begin
          idx_d = idx_q + ADDR_W'(1);
        end
      end
      BS_MAX_RUN: begin
        if ($signed(rdata_q) > $signed(acc_q)) begin
          acc_d = rdata_q;
        end
        if (at_last) begin
          state_d = BS_DONE;
        end else begin
          idx_d = idx_q + ADDR_W'(1);
        end
      end
      BS_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = BS_IDLE;
        end
      end
      default: begin
        state_d = BS_IDLE;
      end
    endcase
  end

  always_comb begin
    out_max_d = '0;
    if (cmd_q.kind == CK_MAX) begin
      out_max_d = RES_W'(acc_q);
    end else if (cmd_q.kind == CK_REPORT && cmd_q.neg_min) begin
      out_max_d = RES_W'(SIGN_MIN);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    cmd_q <= cmd_d;
    if (out_load) begin
      out_max_q    <= out_max_d;
      out_status_q <= cmd_q.status;
    end
  end

  assign init_done_o = state_q != BS_CLEAR;
  assign out_valid_o = out_valid_q;
  assign max_value_o = out_max_q;
  assign status_o    = out_status_q;

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == BS_DONE)
    else $error("result appeared outside the done step");

  a_max_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BS_MAX_RUN |-> idx_q <= cmd_q.last_addr)
    else $error("max walk ran past the range end");

  a_fin_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BS_FIN_RUN |-> idx_q <= cmd_q.last_addr)
    else $error("prefix walk ran past the used length");

  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BS_CLEAR |-> !q_pop_o && !out_valid_q)
    else $error("item handled during the clearing pass");

endmodule

### bench/range_max_checker.sv
`timescale 1ns / 100ps
// range_max_checker: watches the item, result and length channels of the range add / range max
// unit, keeps its own copy of the store and compares each result in order; needs rarm_pkg
module range_max_checker
  import rarm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [1:0]       op_i,
  input  logic [POS_W-1:0] low_position_i,
  input  logic [POS_W-1:0] high_position_i,
  input  logic [AMT_W-1:0] amount_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [RES_W-1:0] max_value_i,
  input  logic [1:0]       status_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [CFG_W-1:0] length_in_use_i,
  output int               mismatch_count_o,
  output int               pending_o,
  output int               accepted_o
);

  typedef struct packed {
    logic [RES_W-1:0] max_value;
    status_e          status;
  } range_outcome_t;

  logic [VALUE_WIDTH-1:0] level_store [DEPTH];
  logic [CFG_W-1:0]       length_copy;
  range_outcome_t         awaited_outcomes [$];
  range_outcome_t         oldest;
  int                     items_in;
  int                     results_out;
  int                     mismatch_count = 0;

  assign mismatch_count_o = mismatch_count;
  assign pending_o        = items_in - results_out;
  assign accepted_o       = items_in;

  task automatic report_mismatch(input string what, input logic [RES_W-1:0] got,
                                 input logic [RES_W-1:0] want);
    $display("%0t: %s mismatch, got %h expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // applies one item to the local store and returns the result it must give
  function automatic range_outcome_t predict_range_op(input logic [1:0] op,
                                                      input logic [POS_W-1:0] lo,
                                                      input logic [POS_W-1:0] hi,
                                                      input logic [AMT_W-1:0] amount);
    range_outcome_t         outcome;
    int unsigned            span;
    logic [VALUE_WIDTH-1:0] delta;
    logic [VALUE_WIDTH-1:0] best;
    span              = (length_copy > DEPTH) ? DEPTH : length_copy;
    delta             = VALUE_WIDTH'($signed(amount));
    outcome.max_value = '0;
    outcome.status    = ST_OK;
    case (op)
      OP_FIN: begin
        for (int i = 1; i < int'(span); i++) begin
          level_store[i] = level_store[i] + level_store[i-1];
        end
      end
      OP_ADD, OP_MAX: begin
        if (lo == 0 || lo > span || hi > span) begin
          outcome.status = ST_RANGE;
        end else if (hi < lo) begin
          outcome.status = ST_EMPTY;
          if (op == OP_MAX) outcome.max_value = RES_W'(SIGN_MIN);
        end else if (op == OP_ADD) begin
          level_store[ADDR_W'(lo - 1)] = level_store[ADDR_W'(lo - 1)] + delta;
          // an add that reaches the last used entry has nothing to take off
          if (hi < span) level_store[ADDR_W'(hi)] = level_store[ADDR_W'(hi)] - delta;
        end else begin
          best = SIGN_MIN;
          for (int i = int'(lo) - 1; i < int'(hi); i++) begin
            if ($signed(level_store[i]) > $signed(best)) best = level_store[i];
          end
          outcome.max_value = RES_W'(best);
        end
      end
      default: begin
        outcome.status = ST_RANGE;
      end
    endcase
    return outcome;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (level_store[i]) level_store[i] = '0;
      length_copy = LEN_RESET;
      awaited_outcomes.delete();
      items_in    <= 0;
      results_out <= 0;
    end else begin
      // results leave before the new item enters, a result never belongs to this edge's item
      if (out_valid_i && out_ready_i) begin
        results_out <= results_out + 1;
        if (awaited_outcomes.size() == 0) begin
          report_mismatch("unexpected result", max_value_i, '0);
        end else begin
          oldest = awaited_outcomes.pop_front();
          if (max_value_i !== oldest.max_value) begin
            report_mismatch("max_value", max_value_i, oldest.max_value);
          end
          if (status_i !== oldest.status) begin
            report_mismatch("status", RES_W'(status_i), RES_W'(oldest.status));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        items_in <= items_in + 1;
        awaited_outcomes.push_back(
          predict_range_op(op_i, low_position_i, high_position_i, amount_i));
      end
      // a new length applies to items after this edge
      if (cfg_valid_i && cfg_ready_i) length_copy = length_in_use_i;
    end
  end

endmodule

### bench/tb_range_add_then_range_max_unit.sv
`timescale 1ns / 100ps
// tb_range_add_then_range_max_unit: drives items, length writes and result stalls into the
// range add / range max unit and gives the verdict; needs rarm_pkg and range_max_checker
module tb_range_add_then_range_max_unit
  import rarm_pkg::*;
();

  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned HOLD_AT     = 60;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 1100;
  localparam int unsigned POS_MAX     = (1 << POS_W) - 1;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [1:0]              op_i;
  logic [POS_W-1:0]        low_position_i;
  logic [POS_W-1:0]        high_position_i;
  logic signed [AMT_W-1:0] amount_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic signed [RES_W-1:0] max_value_o;
  logic [1:0]              status_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_W-1:0]        length_in_use_i;

  int          mismatch_count;
  int          pending;
  int          accepted;
  bit          calm_tail = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned cycle_count = 0;

  range_add_then_range_max_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .low_position_i  (low_position_i),
    .high_position_i (high_position_i),
    .amount_i        (amount_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .max_value_o     (max_value_o),
    .status_o        (status_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .length_in_use_i (length_in_use_i)
  );

  range_max_checker range_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .op_i             (op_i),
    .low_position_i   (low_position_i),
    .high_position_i  (high_position_i),
    .amount_i         (amount_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .max_value_i      (max_value_o),
    .status_i         (status_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .length_in_use_i  (length_in_use_i),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .accepted_o       (accepted)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stall bursts, quiet stretches and one long hold-off
  initial begin
    out_ready_i <= 1'b1;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!hold_done && accepted >= HOLD_AT) begin
        // queue fills up behind this and the item side stalls
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_ready_i <= 1'b1;
        hold_done = 1'b1;
      end else if (!calm_tail && $urandom_range(0, 11) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if ($urandom_range(0, 15) == 0) begin
        repeat ($urandom_range(20, 80)) @(posedge clk_i);
      end
      @(posedge clk_i);
    end
  end

  task automatic send_item(input logic [1:0] op, input int unsigned lo, input int unsigned hi,
                           input logic [AMT_W-1:0] amt);
    if (!calm_tail && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    op_i            <= op;
    low_position_i  <= POS_W'(lo);
    high_position_i <= POS_W'(hi);
    amount_i        <= amt;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending > 0);
  endtask

  task automatic write_length(input int unsigned len);
    wait_results_drained();
    cfg_valid_i     <= 1'b1;
    length_in_use_i <= CFG_W'(len);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random_item(input int unsigned eff_len);
    int unsigned      pick;
    int unsigned      lo;
    int unsigned      hi;
    logic [1:0]       op;
    logic [AMT_W-1:0] amt;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0:       amt = 32'h8000_0000;
      1:       amt = 32'h7fff_ffff;
      2:       amt = '1;
      3:       amt = AMT_W'($urandom_range(0, 3));
      default: amt = $urandom;
    endcase
    if (eff_len == 0 || pick < 8) begin
      // noise: any opcode, positions anywhere in the field
      op = 2'($urandom_range(0, 3));
      lo = $urandom_range(0, POS_MAX);
      hi = $urandom_range(0, POS_MAX);
    end else begin
      lo = $urandom_range(1, eff_len);
      hi = $urandom_range(lo, eff_len);
      if (pick < 14) begin
        op = ($urandom_range(0, 1) == 0) ? OP_ADD : OP_MAX;
        hi = lo - 1;
      end else if (pick < 20) begin
        op = OP_FIN;
      end else if (pick < 62) begin
        op = OP_ADD;
        if ($urandom_range(0, 3) == 0) hi = eff_len;
      end else begin
        op = OP_MAX;
        // short windows keep most walks cheap
        if ($urandom_range(0, 1) == 0 && lo + 15 < eff_len) hi = lo + $urandom_range(0, 15);
      end
    end
    send_item(op, lo, hi, amt);
  endtask

  task automatic run_phase(input int unsigned len, input int unsigned count);
    write_length(len);
    repeat (count) send_random_item((len > DEPTH) ? DEPTH : len);
  endtask

  initial begin
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    op_i            <= OP_ADD;
    low_position_i  <= '0;
    high_position_i <= '0;
    amount_i        <= '0;
    cfg_valid_i     <= 1'b0;
    length_in_use_i <= LEN_RESET;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed items at the reset length
    send_item(OP_MAX, 1, 1024, '0);
    send_item(OP_ADD, 1, 1024, 32'h7fff_ffff);
    send_item(OP_ADD, 0, 3, 32'd5);
    send_item(OP_ADD, 1025, 1025, 32'd5);
    send_item(OP_MAX, POS_MAX, POS_MAX, '0);
    send_item(OP_ADD, 1, 1025, 32'd5);
    send_item(OP_ADD, 5, 4, 32'd9);
    send_item(OP_MAX, 1, 0, '0);
    send_item(OP_UNUSED, 3, 7, 32'd1);
    send_item(OP_ADD, 1024, 1024, 32'h8000_0000);
    send_item(OP_ADD, 2, 3, 32'hffff_ffff);
    send_item(OP_ADD, 512, 700, 32'h1234_5678);
    send_item(OP_FIN, 0, 0, '0);
    send_item(OP_MAX, 1, 1024, '0);
    send_item(OP_MAX, 1024, 1024, '0);
    send_item(OP_MAX, 2, 3, '0);
    send_item(OP_MAX, 0, 0, '0);
    send_item(OP_FIN, 0, 0, '0);
    send_item(OP_MAX, 1, 1, '0);
    send_item(OP_MAX, 600, 1024, '0);
    // zero length: everything out of range, finalize does nothing
    write_length(0);
    send_item(OP_ADD, 1, 1, 32'd5);
    send_item(OP_MAX, 1, 1, '0);
    send_item(OP_FIN, 0, 0, '0);

    run_phase(16, 48);
    run_phase(1, 40);
    run_phase(2, 40);
    run_phase(1024, 48);
    run_phase(37, 48);
    run_phase(POS_MAX, 48);
    run_phase(1023, 48);
    run_phase(8, 48);
    run_phase(300, 48);
    run_phase(5, 40);
    run_phase(3, 40);
    calm_tail = 1'b1;
    run_phase(64, 70);

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
